// File: hw/rtl/sme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sme_pkg;

  localparam int DATA_DEPTH    = 64;
  localparam int RETURN_DEPTH  = 64;
  localparam int ADDRESS_WIDTH = 16;

  // level counters hold 0..depth, store indexes 0..depth-1
  localparam int DLVL_W = $clog2(DATA_DEPTH + 1);
  localparam int DIDX_W = $clog2(DATA_DEPTH);
  localparam int RLVL_W = $clog2(RETURN_DEPTH + 1);
  localparam int RIDX_W = $clog2(RETURN_DEPTH);

  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_DUP       = 4'd1;
  localparam logic [3:0] OP_SWAP      = 4'd2;
  localparam logic [3:0] OP_DROP      = 4'd3;
  localparam logic [3:0] OP_NOT       = 4'd4;
  localparam logic [3:0] OP_ADD       = 4'd5;
  localparam logic [3:0] OP_LITERAL   = 4'd6;
  localparam logic [3:0] OP_JUMP      = 4'd7;
  localparam logic [3:0] OP_JUMP_ZERO = 4'd8;
  localparam logic [3:0] OP_CALL      = 4'd9;
  localparam logic [3:0] OP_EXIT      = 4'd10;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXIT_HALT  = 3'd1;
  localparam logic [2:0] ST_BYE        = 3'd2;
  localparam logic [2:0] ST_DATA_UNDER = 3'd3;
  localparam logic [2:0] ST_DATA_OVER  = 3'd4;
  localparam logic [2:0] ST_RET_UNDER  = 3'd5;
  localparam logic [2:0] ST_RET_OVER   = 3'd6;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand;
    logic               is_bye;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        next_address;
    logic signed [31:0] top_value;
    logic [6:0]         data_count;
    logic [6:0]         return_count;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/sme_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/stack_machine_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-stack threaded-code execute unit. One instruction transaction is taken into an input
// register and retired from there into the result register, so a new instruction can be
// accepted every cycle unless out_stall holds the result register back, which keeps the
// instruction waiting in the input register. The top two data stack entries and the top return stack
// entry live in flip-flops; deeper entries sit in two RAMs with one write and one read port
// each, whose registered read port always prefetches the entry just below the registered
// ones, with a bypass for the entry written in the same cycle. No clearing pass is needed
// after reset.
module stack_machine_execute_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sme_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sme_pkg::out_item_t       out_data
);
  import sme_pkg::*;

  localparam int AW = ADDRESS_WIDTH;

  in_item_t  ir_r;
  logic      ir_valid_r;
  out_item_t out_r, out_nxt;
  logic      out_valid_r;
  logic      exec;

  logic [AW-1:0]     pc_r, pc_nxt;
  logic [DLVL_W-1:0] d_r, d_nxt;
  logic [RLVL_W-1:0] r_r, r_nxt;
  logic [31:0]       tos_r, tos_nxt, nos_r, nos_nxt;
  logic [AW-1:0]     rtos_r, rtos_nxt;

  // data RAM and prefetch bypass
  logic              dwe;
  logic [DIDX_W-1:0] dwaddr, draddr;
  logic [31:0]       drdata, dthird;
  logic              dbyp_r, dbyp_nxt;
  logic [31:0]       dbyp_data_r;

  // return RAM and prefetch bypass
  logic              rwe;
  logic [RIDX_W-1:0] rwaddr, rraddr;
  logic [AW-1:0]     rrdata, rsecond;
  logic              rbyp_r, rbyp_nxt;
  logic [AW-1:0]     rbyp_data_r;

  logic [2:0]    status;
  logic [AW-1:0] pc_inc1, pc_inc2, pc_branch, pc_target;

  assign exec      = ir_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = ir_valid_r && !exec;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dthird  = dbyp_r ? dbyp_data_r : drdata;
  assign rsecond = rbyp_r ? rbyp_data_r : rrdata;

  assign pc_inc1   = pc_r + AW'(1);
  assign pc_inc2   = pc_r + AW'(2);
  assign pc_branch = pc_inc2 + AW'(ir_r.operand);

  always_comb begin
    status    = ST_OK;
    pc_target = pc_inc1;
    d_nxt     = d_r;
    r_nxt     = r_r;
    tos_nxt   = tos_r;
    nos_nxt   = nos_r;
    rtos_nxt  = rtos_r;
    dwe       = 1'b0;
    rwe       = 1'b0;
    dwaddr    = DIDX_W'(d_r - DLVL_W'(2));
    rwaddr    = RIDX_W'(r_r - RLVL_W'(1));
    if (exec) begin
      if (ir_r.is_bye) begin
        status = ST_BYE;
      end else begin
        unique case (ir_r.opcode)
          OP_DUP: begin
            if (d_r == '0) begin
              status = ST_DATA_UNDER;
            end else if (d_r >= DLVL_W'(DATA_DEPTH)) begin
              status = ST_DATA_OVER;
            end else begin
              dwe     = d_r >= DLVL_W'(2);
              nos_nxt = tos_r;
              d_nxt   = d_r + DLVL_W'(1);
            end
          end
          OP_SWAP: begin
            if (d_r < DLVL_W'(2)) begin
              status = ST_DATA_UNDER;
            end else begin
              tos_nxt = nos_r;
              nos_nxt = tos_r;
            end
          end
          OP_DROP: begin
            if (d_r == '0) begin
              status = ST_DATA_UNDER;
            end else begin
              tos_nxt = nos_r;
              nos_nxt = dthird;
              d_nxt   = d_r - DLVL_W'(1);
            end
          end
          OP_NOT: begin
            if (d_r == '0) begin
              status = ST_DATA_UNDER;
            end else begin
              tos_nxt = (tos_r == '0) ? 32'h01 : '0;
            end
          end
          OP_ADD: begin
            if (d_r < DLVL_W'(2)) begin
              status = ST_DATA_UNDER;
            end else begin
              tos_nxt = nos_r + tos_r;
              nos_nxt = dthird;
              d_nxt   = d_r - DLVL_W'(1);
            end
          end
          OP_LITERAL: begin
            if (d_r >= DLVL_W'(DATA_DEPTH)) begin
              status = ST_DATA_OVER;
            end else begin
              dwe       = d_r >= DLVL_W'(2);
              nos_nxt   = tos_r;
              tos_nxt   = ir_r.operand;
              d_nxt     = d_r + DLVL_W'(1);
              pc_target = pc_inc2;
            end
          end
          OP_JUMP: begin
            pc_target = pc_branch;
          end
          OP_JUMP_ZERO: begin
            if (d_r == '0) begin
              status = ST_DATA_UNDER;
            end else begin
              tos_nxt   = nos_r;
              nos_nxt   = dthird;
              d_nxt     = d_r - DLVL_W'(1);
              pc_target = (tos_r == '0) ? pc_branch : pc_inc2;
            end
          end
          OP_CALL: begin
            if (r_r >= RLVL_W'(RETURN_DEPTH)) begin
              status = ST_RET_OVER;
            end else begin
              rwe       = r_r != '0;
              rtos_nxt  = pc_inc1;
              r_nxt     = r_r + RLVL_W'(1);
              pc_target = AW'(ir_r.operand);
            end
          end
          OP_EXIT: begin
            if (r_r == '0) begin
              status = ST_EXIT_HALT;
            end else begin
              rtos_nxt  = rsecond;
              r_nxt     = r_r - RLVL_W'(1);
              pc_target = rtos_r;
            end
          end
          default: begin
            // nop and undefined opcodes
          end
        endcase
      end
    end
    pc_nxt = (exec && status == ST_OK) ? pc_target : pc_r;
    // keep the prefetch pointing just below the registered entries
    draddr   = DIDX_W'(d_nxt - DLVL_W'(3));
    rraddr   = RIDX_W'(r_nxt - RLVL_W'(2));
    dbyp_nxt = dwe && (dwaddr == draddr);
    rbyp_nxt = rwe && (rwaddr == rraddr);

    out_nxt.status       = status;
    out_nxt.next_address = 16'(pc_nxt);
    out_nxt.top_value    = (d_nxt == '0) ? '0 : tos_nxt;
    out_nxt.data_count   = 7'(d_nxt);
    out_nxt.return_count = 7'(r_nxt);
  end

  sme_ram #(
    .WIDTH (32),
    .DEPTH (DATA_DEPTH)
  ) u_data_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (nos_r),
    .raddr (draddr),
    .rdata (drdata)
  );

  sme_ram #(
    .WIDTH (AW),
    .DEPTH (RETURN_DEPTH)
  ) u_return_ram (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (rtos_r),
    .raddr (rraddr),
    .rdata (rrdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      d_r         <= '0;
      r_r         <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        ir_valid_r <= 1'b1;
      end else if (exec) begin
        ir_valid_r <= 1'b0;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pc_r <= pc_nxt;
      d_r  <= d_nxt;
      r_r  <= r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_r <= in_data;
    end
    if (exec) begin
      out_r <= out_nxt;
    end
    tos_r       <= tos_nxt;
    nos_r       <= nos_nxt;
    rtos_r      <= rtos_nxt;
    dbyp_r      <= dbyp_nxt;
    dbyp_data_r <= nos_r;
    rbyp_r      <= rbyp_nxt;
    rbyp_data_r <= rtos_r;
  end

endmodule
`default_nettype wire
